/* rtl/bmh_pkg.sv */
`default_nettype none

package bmh_pkg;

	localparam int MAX_PATTERN   = 64;
	localparam int SUBJECT_DEPTH = 4096;
	localparam int ALPHABET      = 256;
	localparam int BYTE_W        = 8;
	localparam int POS_W         = 13;

	typedef logic [POS_W-1:0] pos_t;

	localparam logic [1:0] OP_PATTERN = 2'd0;
	localparam logic [1:0] OP_TRANS   = 2'd1;
	localparam logic [1:0] OP_SUBJECT = 2'd2;

	localparam logic REG_REVERSE_MODE    = 1'b0;
	localparam logic REG_USE_TRANSLATION = 1'b1;

	typedef struct packed {
		logic [1:0]        op;
		logic [BYTE_W-1:0] data_byte;
		logic [BYTE_W-1:0] entry_index;
		logic              last;
	} in_beat_t;

	typedef struct packed {
		logic found;
		pos_t position;
		logic overflow;
	} out_beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic clr;
		logic en;
		logic rev;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/bmh_ram.sv */
`default_nettype none

module bmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/bmh_cell.sv */
`default_nettype none

module bmh_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         pat_we,
	input  wire logic [bmh_pkg::BYTE_W-1:0]   pat_byte,
	input  wire bmh_pkg::cell_ctl_t           ctl,
	input  wire logic [bmh_pkg::BYTE_W-1:0]   sym,
	input  wire logic                         head_in,
	input  wire logic                         tail_in,
	output logic                              match
);

	logic [bmh_pkg::BYTE_W-1:0] pat_q;
	logic                       match_q;

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_q <= pat_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.clr) begin
			match_q <= 1'b0;
		end else if (ctl.en) begin
			match_q <= (ctl.rev ? tail_in : head_in) && (sym == pat_q);
		end
	end

	assign match = match_q;

endmodule

`default_nettype wire

/* rtl/bmh_substring_search.sv */
`default_nettype none

// Byte substring search. Pattern bytes, translation table writes and subject
// bytes each load one per beat. The beat that carries the last subject byte
// starts the search: the stored subject is read one byte per cycle from the
// subject memory, mapped through the translation memory when translation is
// enabled and fed into a row of MAX_PATTERN comparison cells. The search ends
// at the first match found; an empty pattern is reported as found and a subject
// shorter than the pattern as not found, without reading the subject.
// No beat is accepted while a search runs. Forward mode reports the first match,
// reverse mode the last.
module bmh_substring_search #(
	parameter int MAX_PATTERN   = bmh_pkg::MAX_PATTERN,
	parameter int SUBJECT_DEPTH = bmh_pkg::SUBJECT_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic                cfg_data,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire bmh_pkg::in_beat_t   item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output bmh_pkg::out_beat_t       result
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LW    = $clog2(SUBJECT_DEPTH + 1);
	localparam int AW    = $clog2(SUBJECT_DEPTH);
	localparam int CW    = (LW > LEN_W) ? LW : LEN_W;
	localparam int BW    = bmh_pkg::BYTE_W;

	bmh_pkg::state_t          state_q, state_d;
	logic                     rev_q, utr_q;
	logic [LEN_W-1:0]         plen_q;
	logic                     popen_q;
	logic [LW-1:0]            slen_q;
	logic                     sopen_q;
	logic                     ovf_q;
	logic [bmh_pkg::ALPHABET-1:0] tvalid_q;
	logic [LW-1:0]            cnt_q, cnt_d;
	logic                     v_s1, v_s2, v_s3;
	logic [AW-1:0]            addr_s1, addr_s2, addr_s3;
	logic [BW-1:0]            raw_s2;
	logic                     tv_s2;
	logic                     res_found_q, res_found_d;
	bmh_pkg::pos_t            res_pos_q, res_pos_d;
	logic                     res_load;
	logic                     out_valid_q;
	bmh_pkg::out_beat_t       out_q;
	logic                     out_load;

	logic                     acc;
	logic [LEN_W-1:0]         pidx;
	logic [LW-1:0]            sidx;
	logic                     pat_we, sub_we, tr_we;
	logic                     issue;
	logic [AW-1:0]            rd_addr;
	logic [BW-1:0]            sub_rdata, tr_rdata, sym;
	bmh_pkg::cell_ctl_t       ctl;
	logic [MAX_PATTERN-1:0]   match;
	logic [IDX_W-1:0]         tail_idx;
	logic                     hit;
	bmh_pkg::pos_t            hit_pos;

	assign acc    = item_valid && item_ready;
	assign pidx   = popen_q ? plen_q : '0;
	assign sidx   = sopen_q ? slen_q : '0;
	assign pat_we = acc && (item.op == bmh_pkg::OP_PATTERN)
		&& (pidx < LEN_W'(MAX_PATTERN));
	assign sub_we = acc && (item.op == bmh_pkg::OP_SUBJECT)
		&& (sidx < LW'(SUBJECT_DEPTH));
	assign tr_we  = acc && (item.op == bmh_pkg::OP_TRANS);

	assign rd_addr = rev_q ? AW'(slen_q - LW'(1) - cnt_q) : AW'(cnt_q);

	bmh_ram #(.WIDTH(BW), .DEPTH(SUBJECT_DEPTH)) u_subject_ram (
		.clk   (clk),
		.we    (sub_we),
		.waddr (sidx[AW-1:0]),
		.wdata (item.data_byte),
		.raddr (rd_addr),
		.rdata (sub_rdata)
	);

	bmh_ram #(.WIDTH(BW), .DEPTH(bmh_pkg::ALPHABET)) u_trans_ram (
		.clk   (clk),
		.we    (tr_we),
		.waddr (item.entry_index),
		.wdata (item.data_byte),
		.raddr (sub_rdata),
		.rdata (tr_rdata)
	);

	// An entry never written keeps the identity mapping.
	assign sym = (utr_q && tv_s2) ? tr_rdata : raw_s2;

	assign tail_idx = IDX_W'(plen_q - LEN_W'(1));

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic head_in, tail_in;

		if (k == 0) begin : g_head
			assign head_in = 1'b1;
		end else begin : g_mid
			assign head_in = match[k-1];
		end

		if (k == MAX_PATTERN - 1) begin : g_end
			assign tail_in = (IDX_W'(k) == tail_idx);
		end else begin : g_inner
			assign tail_in = (IDX_W'(k) == tail_idx) || match[k+1];
		end

		bmh_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.pat_we   (pat_we && (pidx[IDX_W-1:0] == IDX_W'(k))),
			.pat_byte (item.data_byte),
			.ctl      (ctl),
			.sym      (sym),
			.head_in  (head_in),
			.tail_in  (tail_in),
			.match    (match[k])
		);
	end

	assign hit     = rev_q ? match[0] : match[tail_idx];
	assign hit_pos = rev_q ? bmh_pkg::pos_t'(addr_s3)
		: bmh_pkg::pos_t'(CW'(addr_s3) + CW'(1) - CW'(plen_q));

	always_comb begin
		state_d     = state_q;
		item_ready  = 1'b0;
		issue       = 1'b0;
		cnt_d       = cnt_q;
		ctl.clr     = 1'b0;
		ctl.en      = 1'b0;
		ctl.rev     = rev_q;
		res_load    = 1'b0;
		res_found_d = 1'b0;
		res_pos_d   = '0;
		out_load    = 1'b0;
		unique case (state_q)
			bmh_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (acc && (item.op == bmh_pkg::OP_SUBJECT) && item.last) begin
					state_d = bmh_pkg::ST_CHECK;
				end
			end
			bmh_pkg::ST_CHECK: begin
				ctl.clr = 1'b1;
				cnt_d   = '0;
				if (plen_q == '0) begin
					res_load    = 1'b1;
					res_found_d = 1'b1;
					res_pos_d   = rev_q ? bmh_pkg::pos_t'(slen_q) : '0;
					state_d     = bmh_pkg::ST_RESULT;
				end else if (CW'(slen_q) < CW'(plen_q)) begin
					res_load = 1'b1;
					state_d  = bmh_pkg::ST_RESULT;
				end else begin
					state_d = bmh_pkg::ST_RUN;
				end
			end
			bmh_pkg::ST_RUN: begin
				ctl.en = v_s2;
				if (v_s3 && hit) begin
					res_load    = 1'b1;
					res_found_d = 1'b1;
					res_pos_d   = hit_pos;
					state_d     = bmh_pkg::ST_RESULT;
				end else if ((cnt_q == slen_q) && !v_s1 && !v_s2 && !v_s3) begin
					res_load = 1'b1;
					state_d  = bmh_pkg::ST_RESULT;
				end else if (cnt_q != slen_q) begin
					issue = 1'b1;
					cnt_d = cnt_q + LW'(1);
				end
			end
			bmh_pkg::ST_RESULT: begin
				if (!out_valid_q || result_ready) begin
					out_load = 1'b1;
					state_d  = bmh_pkg::ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmh_pkg::ST_IDLE;
			rev_q       <= 1'b0;
			utr_q       <= 1'b0;
			plen_q      <= '0;
			popen_q     <= 1'b0;
			slen_q      <= '0;
			sopen_q     <= 1'b0;
			ovf_q       <= 1'b0;
			tvalid_q    <= '0;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			v_s1    <= issue;
			v_s2    <= v_s1 && (state_q == bmh_pkg::ST_RUN);
			v_s3    <= v_s2 && (state_q == bmh_pkg::ST_RUN);
			if (cfg_we) begin
				unique case (cfg_index)
					bmh_pkg::REG_REVERSE_MODE:    rev_q <= cfg_data;
					bmh_pkg::REG_USE_TRANSLATION: utr_q <= cfg_data;
				endcase
			end
			if (acc) begin
				case (item.op)
					bmh_pkg::OP_PATTERN: begin
						plen_q  <= pat_we ? pidx + LEN_W'(1) : pidx;
						popen_q <= !item.last;
					end
					bmh_pkg::OP_TRANS: begin
						tvalid_q[item.entry_index] <= 1'b1;
					end
					bmh_pkg::OP_SUBJECT: begin
						slen_q  <= sub_we ? sidx + LW'(1) : sidx;
						ovf_q   <= !sub_we || (sopen_q && ovf_q);
						sopen_q <= !item.last;
					end
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		addr_s2 <= addr_s1;
		addr_s3 <= addr_s2;
		raw_s2  <= sub_rdata;
		tv_s2   <= tvalid_q[sub_rdata];
		if (res_load) begin
			res_found_q <= res_found_d;
			res_pos_q   <= res_pos_d;
		end
		if (out_load) begin
			out_q.found    <= res_found_q;
			out_q.position <= res_pos_q;
			out_q.overflow <= ovf_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmh_pkg::ST_RUN) |-> (cnt_q <= slen_q))
		else $error("subject read count passed the stored length");

	a_hit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmh_pkg::ST_RUN && v_s3 && hit) |=> (state_q == bmh_pkg::ST_RESULT))
		else $error("match seen but the search did not end");

	a_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmh_pkg::ST_CHECK) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("stale bytes in the search pipeline at search start");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bmh_pkg::ST_RESULT && out_valid_q && !result_ready)
		|=> (state_q == bmh_pkg::ST_RESULT))
		else $error("result register overwritten before its beat was taken");

endmodule

`default_nettype wire
